>>> hw/rtl/note_tone_generator_with_decay_defines.svh
// Assertion macros shared by the tone generator RTL.
`ifndef NOTE_TONE_GENERATOR_WITH_DECAY_DEFINES_SVH
`define NOTE_TONE_GENERATOR_WITH_DECAY_DEFINES_SVH

`ifndef SYNTHESIS

`define NTG_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ntg assertion failed");

`define NTG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ntg assertion failed");

`else

`define NTG_ASSERT_IMPL(label, clk, rst_n, pre, post)

`define NTG_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

>>> hw/rtl/ntg_pkg.sv
// Types, constants and the tone table function of the tone generator.
`timescale 1ns / 1ps

package ntg_pkg;

    localparam int unsigned CLOCK_HZ_DEFAULT  = 16000000;
    localparam int unsigned TOP_LIMIT_DEFAULT = 256;

    localparam int unsigned NOTE_W  = 7;
    localparam int unsigned VEL_W   = 8;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned TOP_W   = 8;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned PROD_W  = TICKS_W + DUTY_W;

    localparam int unsigned ROM_DEPTH = 2 ** NOTE_W;

    localparam logic [TICKS_W-1:0] DECAY_RESET = 16'd1000;

    localparam logic [63:0] SEMI_SCALE = 64'd10000000000;
    localparam logic [63:0] TONE_DEN   = 64'd880 * SEMI_SCALE;

    localparam logic [63:0] SEMI_RATIO [12] = '{
        64'd10000000000, 64'd10594630944, 64'd11224620483, 64'd11892071150,
        64'd12599210499, 64'd13348398542, 64'd14142135624, 64'd14983070769,
        64'd15874010520, 64'd16817928305, 64'd17817974363, 64'd18877486254
    };

    localparam int unsigned CHAIN_SHIFT [7] = '{0, 3, 2, 1, 1, 1, 2};

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [TOP_W-1:0]  top;
    } tone_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        arith_op_t          op;
        logic [TICKS_W-1:0] a;
        logic [TICKS_W-1:0] b;
        logic               in_bit;
    } arith_ctrl_t;

    typedef struct packed {
        logic [PROD_W-1:0]  product;
        logic [TICKS_W-1:0] rem;
        logic               qbit;
    } arith_res_t;

    // Evaluated only with constant arguments, so each entry becomes a constant.
    function automatic tone_t tone_entry(input int unsigned n,
                                         input logic [63:0] clk_hz,
                                         input int unsigned top_limit);
        int          t;
        int          q;
        int          r;
        logic [63:0] val;
        logic [63:0] c;
        tone_t       e;
        logic        done;
        t = 129 - int'(n);
        q = t / 12 - 5;
        r = t % 12;
        val = clk_hz * SEMI_RATIO[r[3:0]];
        if (q >= 0)
        begin
            c = (val << q) / TONE_DEN;
        end
        else
        begin
            c = (val / TONE_DEN) >> (-q);
        end
        e.code = 3'd7;
        e.top  = TOP_W'(top_limit - 1);
        done   = 1'b0;
        for (int i = 0; i < 7; i++)
        begin
            if (!done)
            begin
                c = c >> CHAIN_SHIFT[i];
                if (c < 64'(top_limit))
                begin
                    e.code = CODE_W'(i + 1);
                    e.top  = c[TOP_W-1:0];
                    done   = 1'b1;
                end
            end
        end
        return e;
    endfunction

endpackage

>>> hw/rtl/ntg_arith.sv
// Shared arithmetic unit: a 16 by 8 multiplier and one restoring division step.
`timescale 1ns / 1ps
`include "note_tone_generator_with_decay_defines.svh"

module ntg_arith
    import ntg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  arith_ctrl_t ctrl,
    output arith_res_t  res
);

    logic [TICKS_W:0] trial;
    logic             fits;

    always_comb
    begin
        trial       = {ctrl.a, ctrl.in_bit};
        fits        = trial >= {1'b0, ctrl.b};
        res.product = '0;
        res.rem     = '0;
        res.qbit    = 1'b0;
        unique case (ctrl.op)
            OP_MUL:
            begin
                res.product = ctrl.a * ctrl.b[DUTY_W-1:0];
            end
            OP_DIV:
            begin
                res.qbit = fits;
                if (fits)
                begin
                    res.rem = TICKS_W'(trial - {1'b0, ctrl.b});
                end
                else
                begin
                    res.rem = trial[TICKS_W-1:0];
                end
            end
            default:
            begin
                res.product = '0;
            end
        endcase
    end

    `NTG_ASSERT_IMPL(a_rem_below_divisor, clk, rst_n, ctrl.op == OP_DIV && ctrl.a < ctrl.b, res.rem < ctrl.b)
    `NTG_ASSERT_IMPL(a_mul_no_qbit, clk, rst_n, ctrl.op == OP_MUL, !res.qbit)
    `NTG_ASSERT_IMPL(a_div_no_product, clk, rst_n, ctrl.op == OP_DIV, res.product == '0)

endmodule

>>> hw/rtl/note_tone_generator_with_decay.sv
// Top level of the note tone generator with linear duty decay.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tuser: kind; tdata: note, velocity
//   m_*       out  m_tvalid/m_tready  tdata: prescale_code, top_count, compare, duty
//   cfg_*     in   cfg_valid/cfg_ready  cfg_data: decay_ticks
//
// A note start, a tick outside the decay and the tick that ends it pass from the
// load state through the compare and output states into the output register; a tick
// with a new duty also passes the multiply state and the shared unit's 8 division steps.
// Input is accepted only in the idle state, so an item waits until the last one is sent.
// A result waiting on m_tready holds the sequencer in its output state.
// Reset is asynchronous, active low; decay_ticks resets to 1000.
`timescale 1ns / 1ps
`include "note_tone_generator_with_decay_defines.svh"

module note_tone_generator_with_decay
    import ntg_pkg::*;
#(
    parameter int unsigned CLOCK_HZ  = CLOCK_HZ_DEFAULT,
    parameter int unsigned TOP_LIMIT = TOP_LIMIT_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // note [6:0], velocity [14:7], zero [15]
    input  logic [0:0]          s_tuser,   // kind [0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // prescale_code [2:0], top_count [10:3],
                                           // compare_value [18:11], duty_now [26:19],
                                           // zero [31:27]
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TICKS_W-1:0]  cfg_data   // decay_ticks
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_CMP  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    tone_t tone_rom [ROM_DEPTH];

    for (genvar g = 0; g < ROM_DEPTH; g++)
    begin : g_rom
        assign tone_rom[g] = tone_entry(32'(g), 64'(CLOCK_HZ), TOP_LIMIT);
    end

    logic [TICKS_W-1:0] decay_ticks_reg, decay_ticks_next;
    logic [NOTE_W-1:0]  cur_note_reg, cur_note_next;
    logic [CODE_W-1:0]  prescale_reg, prescale_next;
    logic [TOP_W-1:0]   top_reg, top_next;
    logic [DUTY_W-1:0]  attack_reg, attack_next;
    logic [TICKS_W-1:0] elapsed_reg, elapsed_next;
    logic               decaying_reg, decaying_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;

    logic               kind_reg, kind_next;
    logic [NOTE_W-1:0]  note_reg, note_next;
    logic [VEL_W-1:0]   vel_reg, vel_next;
    logic [TICKS_W-1:0] rem_reg, rem_next;
    logic [DUTY_W-1:0]  low_reg, low_next;
    logic [DUTY_W-1:0]  quot_reg, quot_next;
    logic [DUTY_W-1:0]  cmp_reg, cmp_next;
    logic [31:0]        m_data_reg, m_data_next;

    arith_ctrl_t        actrl;
    arith_res_t         ares;
    tone_t              tone;
    logic [TICKS_W-1:0] elapsed_inc;
    logic               tick_end;

    ntg_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (actrl),
        .res   (ares)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign tone        = tone_rom[note_reg];
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign tick_end    = elapsed_inc >= decay_ticks_reg;

    always_comb
    begin
        actrl.in_bit = low_reg[DUTY_W-1];
        unique case (state_reg)
            ST_DIV:
            begin
                actrl.op = OP_DIV;
                actrl.a  = rem_reg;
                actrl.b  = decay_ticks_reg;
            end
            ST_CMP:
            begin
                actrl.op = OP_MUL;
                actrl.a  = {{(TICKS_W-TOP_W){1'b0}}, top_reg};
                actrl.b  = {{(TICKS_W-DUTY_W){1'b0}}, duty_reg};
            end
            default:
            begin
                actrl.op = OP_MUL;
                actrl.a  = elapsed_reg;
                actrl.b  = {{(TICKS_W-DUTY_W){1'b0}}, attack_reg};
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        decay_ticks_next = decay_ticks_reg;
        cur_note_next    = cur_note_reg;
        prescale_next    = prescale_reg;
        top_next         = top_reg;
        attack_next      = attack_reg;
        elapsed_next     = elapsed_reg;
        decaying_next    = decaying_reg;
        duty_next        = duty_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        kind_next        = kind_reg;
        note_next        = note_reg;
        vel_next         = vel_reg;
        rem_next         = rem_reg;
        low_next         = low_reg;
        quot_next        = quot_reg;
        cmp_next         = cmp_reg;
        m_data_next      = m_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            decay_ticks_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = s_tuser[0];
                    note_next  = s_tdata[NOTE_W-1:0];
                    vel_next   = s_tdata[NOTE_W+VEL_W-1:NOTE_W];
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_CMP;
                if (!kind_reg)
                begin
                    if (note_reg != cur_note_reg && note_reg != '0)
                    begin
                        prescale_next = tone.code;
                        top_next      = tone.top;
                    end
                    cur_note_next = note_reg;
                    attack_next   = (note_reg != '0) ? vel_reg : '0;
                    duty_next     = (note_reg != '0) ? vel_reg : '0;
                    elapsed_next  = '0;
                    decaying_next = 1'b1;
                end
                else if (decaying_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (tick_end)
                    begin
                        duty_next     = '0;
                        decaying_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                rem_next   = ares.product[PROD_W-1:DUTY_W];
                low_next   = ares.product[DUTY_W-1:0];
                quot_next  = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = ares.rem;
                low_next  = {low_reg[DUTY_W-2:0], 1'b0};
                quot_next = {quot_reg[DUTY_W-2:0], ares.qbit};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    duty_next  = attack_reg - {quot_reg[DUTY_W-2:0], ares.qbit};
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmp_next   = ares.product[TOP_W+DUTY_W-1:DUTY_W];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b0, duty_reg, cmp_reg, top_reg, prescale_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            decay_ticks_reg <= DECAY_RESET;
            cur_note_reg    <= '0;
            prescale_reg    <= '0;
            top_reg         <= '0;
            attack_reg      <= '0;
            elapsed_reg     <= '0;
            decaying_reg    <= 1'b0;
            duty_reg        <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            decay_ticks_reg <= decay_ticks_next;
            cur_note_reg    <= cur_note_next;
            prescale_reg    <= prescale_next;
            top_reg         <= top_next;
            attack_reg      <= attack_next;
            elapsed_reg     <= elapsed_next;
            decaying_reg    <= decaying_next;
            duty_reg        <= duty_next;
            cnt_reg         <= cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        note_reg   <= note_next;
        vel_reg    <= vel_next;
        rem_reg    <= rem_next;
        low_reg    <= low_next;
        quot_reg   <= quot_next;
        cmp_reg    <= cmp_next;
        m_data_reg <= m_data_next;
    end

    `NTG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `NTG_ASSERT_IMPL(a_duty_within_attack, clk, rst_n, 1'b1, duty_reg <= attack_reg)
    `NTG_ASSERT_IMPL(a_silent_when_idle, clk, rst_n, !decaying_reg, duty_reg == '0)
    `NTG_ASSERT_IMPL(a_top_clear_before_note, clk, rst_n, prescale_reg == '0, top_reg == '0)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the note tone generator: directed table, then random note phases.
module tb_top;
    import ntg_pkg::*;

    localparam int unsigned RUN_LIMIT     = 1000000;
    localparam int unsigned RANDOM_ITEMS  = 1800;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned DIR_ROWS      = 30;

    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CODE_W-1:0] PRESCALE_OFF  = 3'd0;
    localparam logic [CODE_W-1:0] PRESCALE_1024 = 3'd7;

    localparam int unsigned PRESCALE_DIV [7] = '{1, 8, 32, 64, 128, 256, 1024};

    typedef enum logic [1:0]
    {
        ROW_NOTE,
        ROW_TICK,
        ROW_CFG
    } row_op_t;

    typedef struct packed
    {
        logic [DUTY_W-1:0] duty;
        logic [DUTY_W-1:0] cmp;
        logic [TOP_W-1:0]  top;
        logic [CODE_W-1:0] code;
    } tone_result_t;

    typedef struct packed
    {
        row_op_t            op;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   vel;
        logic [TICKS_W-1:0] cfg;
        logic               known;
        tone_result_t       res;
    } dir_row_t;

    localparam tone_result_t RES_IDLE     = '{8'd0, 8'd0, 8'd0, PRESCALE_OFF};
    localparam tone_result_t RES_LOW_FULL = '{8'd255, 8'd254, 8'd255, PRESCALE_1024};
    localparam tone_result_t RES_LOW_MUTE = '{8'd0, 8'd0, 8'd255, PRESCALE_1024};

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b1, RES_IDLE},
        '{ROW_NOTE, 7'd0,   8'd255, 16'd0,     1'b1, RES_IDLE},
        '{ROW_NOTE, 7'd69,  8'd255, 16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_NOTE, 7'd69,  8'd128, 16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd127, 8'd255, 16'd0,     1'b0, RES_IDLE},
        '{ROW_NOTE, 7'd127, 8'd255, 16'd0,     1'b0, RES_IDLE},
        '{ROW_NOTE, 7'd1,   8'd255, 16'd0,     1'b1, RES_LOW_FULL},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_NOTE, 7'd0,   8'd200, 16'd0,     1'b1, RES_LOW_MUTE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b1, RES_LOW_MUTE},
        '{ROW_CFG,  7'd0,   8'd0,   16'd1,     1'b0, RES_IDLE},
        '{ROW_NOTE, 7'd60,  8'd255, 16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_CFG,  7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_NOTE, 7'd60,  8'd100, 16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_CFG,  7'd0,   8'd0,   16'd65535, 1'b0, RES_IDLE},
        '{ROW_NOTE, 7'd100, 8'd255, 16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_CFG,  7'd0,   8'd0,   16'd3,     1'b0, RES_IDLE},
        '{ROW_NOTE, 7'd2,   8'd255, 16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_NOTE, 7'd127, 8'd0,   16'd0,     1'b0, RES_IDLE},
        '{ROW_TICK, 7'd0,   8'd0,   16'd0,     1'b0, RES_IDLE}
    };

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata   = '0;
    logic [0:0]         s_tuser   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [31:0]        m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [TICKS_W-1:0] cfg_data  = '0;

    // Model of the envelope and tone state.
    logic [TICKS_W-1:0] decay_cfg  = DECAY_RESET;
    logic [NOTE_W-1:0]  cur_note   = '0;
    logic [CODE_W-1:0]  cur_code   = '0;
    logic [TOP_W-1:0]   cur_top    = '0;
    logic [DUTY_W-1:0]  attack     = '0;
    logic [TICKS_W-1:0] elapsed    = '0;
    logic               decaying   = 1'b0;
    logic [DUTY_W-1:0]  cur_duty   = '0;

    tone_result_t pending_tone_q [$];

    int unsigned burst_left = 0;
    int unsigned n_notes    = 0;
    int unsigned n_ticks    = 0;
    int unsigned n_cfg      = 0;
    int unsigned n_checked  = 0;
    int unsigned n_errors   = 0;
    int unsigned cycles     = 0;
    bit          hold_req   = 1'b0;

    note_tone_generator_with_decay i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic tone_result_t step_envelope(input logic kind,
                                                   input logic [NOTE_W-1:0] note,
                                                   input logic [VEL_W-1:0] vel);
        int unsigned  k;
        int unsigned  ri;
        logic [127:0] num;
        logic [127:0] cnt;
        logic [31:0]  drop;
        bit           found;
        tone_result_t r;
        if (kind == KIND_NOTE)
        begin
            if (note != cur_note && note != 0)
            begin
                k   = (129 - int'(note)) / 12;
                ri  = (129 - int'(note)) % 12;
                num = (128'(CLOCK_HZ_DEFAULT) * 128'(SEMI_RATIO[ri])) << k;
                cnt = num / (128'(880) * 128'(SEMI_SCALE) * 128'd32);
                cur_code = PRESCALE_1024;
                cur_top  = TOP_W'(TOP_LIMIT_DEFAULT - 1);
                found    = 1'b0;
                for (int i = 0; i < 7; i++)
                begin
                    if (!found && cnt / PRESCALE_DIV[i] < TOP_LIMIT_DEFAULT)
                    begin
                        cur_code = CODE_W'(i + 1);
                        cur_top  = TOP_W'(cnt / PRESCALE_DIV[i]);
                        found    = 1'b1;
                    end
                end
            end
            cur_note = note;
            attack   = (note != 0) ? vel : '0;
            cur_duty = attack;
            elapsed  = '0;
            decaying = 1'b1;
        end
        else if (decaying)
        begin
            if (elapsed != 16'hFFFF)
            begin
                elapsed = elapsed + 16'd1;
            end
            if (elapsed >= decay_cfg)
            begin
                cur_duty = '0;
                decaying = 1'b0;
            end
            else
            begin
                drop     = (32'(elapsed) * 32'(attack)) / 32'(decay_cfg);
                cur_duty = attack - DUTY_W'(drop);
            end
        end
        r.code = cur_code;
        r.top  = cur_top;
        r.duty = cur_duty;
        r.cmp  = DUTY_W'((16'(cur_top) * 16'(cur_duty)) >> 8);
        return r;
    endfunction

    task automatic send_item(input logic kind, input logic [NOTE_W-1:0] note,
                             input logic [VEL_W-1:0] vel, input bit known,
                             input tone_result_t fixed_res);
        int unsigned  gap;
        tone_result_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, vel, note};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        predicted = step_envelope(kind, note, vel);
        pending_tone_q.push_back(known ? fixed_res : predicted);
        if (kind == KIND_NOTE)
        begin
            n_notes++;
        end
        else
        begin
            n_ticks++;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_tone_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_decay(input logic [TICKS_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        decay_cfg = value;
        n_cfg++;
    endtask

    function automatic logic [TICKS_W-1:0] pick_decay();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 16'd1;
            1: return 16'd65535;
            2: return 16'd1000;
            3, 4, 5, 6: return TICKS_W'($urandom_range(2, 40));
            7, 8: return TICKS_W'($urandom_range(41, 500));
            default: return TICKS_W'($urandom_range(1, 65535));
        endcase
    endfunction

    initial
    begin
        int unsigned         item_goal;
        int unsigned         phase;
        int unsigned         n_tick_run;
        logic [NOTE_W-1:0]   nt;
        int unsigned         sel;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            case (DIR_TAB[i].op)
                ROW_CFG:  write_decay(DIR_TAB[i].cfg);
                ROW_NOTE: send_item(KIND_NOTE, DIR_TAB[i].note, DIR_TAB[i].vel,
                                    DIR_TAB[i].known, DIR_TAB[i].res);
                default:  send_item(KIND_TICK, DIR_TAB[i].note, DIR_TAB[i].vel,
                                    DIR_TAB[i].known, DIR_TAB[i].res);
            endcase
        end

        item_goal = n_notes + n_ticks + RANDOM_ITEMS;
        phase = 0;
        while (n_notes + n_ticks < item_goal)
        begin
            phase++;
            if ($urandom_range(0, 3) != 0)
            begin
                write_decay(pick_decay());
            end
            else
            begin
                drain_results();
            end
            if (phase == 5)
            begin
                hold_req = 1'b1;
            end
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        send_item(KIND_TICK, NOTE_W'($urandom), VEL_W'($urandom), 1'b0, RES_IDLE);
                    end
                end
                sel = $urandom_range(0, 9);
                if (sel == 0)
                begin
                    nt = '0;
                end
                else if (sel == 1)
                begin
                    nt = cur_note;
                end
                else
                begin
                    nt = NOTE_W'($urandom_range(1, 127));
                end
                send_item(KIND_NOTE, nt, VEL_W'($urandom), 1'b0, RES_IDLE);
                if (decay_cfg <= 40)
                begin
                    n_tick_run = $urandom_range(0, int'(decay_cfg) + 4);
                end
                else
                begin
                    n_tick_run = $urandom_range(0, 60);
                end
                repeat (n_tick_run)
                begin
                    send_item(KIND_TICK, NOTE_W'($urandom), VEL_W'($urandom), 1'b0, RES_IDLE);
                end
            end
        end

        drain_results();
        $display("Run covered %0d note starts and %0d ticks under %0d decay settings.",
                 n_notes, n_ticks, n_cfg);
        $display("%0d results were checked and %0d mismatches were found.", n_checked, n_errors);
        if (n_errors == 0 && pending_tone_q.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        int unsigned mode;
        int unsigned span;
        mode = 0;
        span = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 96);
            end
            span--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (span % 4 == 0);
                default: m_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        tone_result_t got;
        tone_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = tone_result_t'(m_tdata[26:0]);
            if (pending_tone_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
                n_errors++;
            end
            else
            begin
                want = pending_tone_q.pop_front();
                n_checked++;
                if (got.code !== want.code)
                begin
                    $display("%0t: prescale_code expected %0d actual %0d",
                             $time, want.code, got.code);
                    n_errors++;
                end
                if (got.top !== want.top)
                begin
                    $display("%0t: top_count expected %0d actual %0d",
                             $time, want.top, got.top);
                    n_errors++;
                end
                if (got.cmp !== want.cmp)
                begin
                    $display("%0t: compare_value expected %0d actual %0d",
                             $time, want.cmp, got.cmp);
                    n_errors++;
                end
                if (got.duty !== want.duty)
                begin
                    $display("%0t: duty_now expected %0d actual %0d",
                             $time, want.duty, got.duty);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == RUN_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_tone_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
